/* hdl/seg_ix_pkg.sv */
package seg_ix_pkg;

    localparam int CW = 16;            // coordinate width
    localparam int XW = 2 * CW + 3;    // cross product width
    localparam int LW = XW / 2;        // low slice of |num| for split multiply
    localparam int HW = XW - LW;       // high slice of |num|
    localparam int NW = CW + XW;       // dividend width
    localparam int QB = CW + 1;        // quotient bits
    localparam int NK = 12;            // cross products: ten tests, den, num
    localparam int KDEN = 10;
    localparam int KNUM = 11;

    typedef logic signed [CW-1:0]   t_crd;
    typedef logic signed [2*CW+1:0] t_prd;
    typedef logic signed [XW-1:0]   t_crs;

    typedef struct packed {
        t_prd l;
        t_prd r;
    } t_pp;

    typedef struct packed {
        logic          hit;
        logic          coll;
        t_crd          a0x;
        t_crd          a0y;
        logic          sx;
        logic          sy;
        logic [XW-1:0] dsor;
        logic [NW-1:0] remx;
        logic [NW-1:0] remy;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
    } t_dv;

    // (u1 - u2) * (v1 - v2), exact
    function automatic t_prd mul_diff(input t_crd u1, input t_crd u2,
                                      input t_crd v1, input t_crd v2);
        logic signed [CW:0] du;
        logic signed [CW:0] dv;
        du = (CW+1)'(u1) - (CW+1)'(u2);
        dv = (CW+1)'(v1) - (CW+1)'(v2);
        return du * dv;
    endfunction

    // terms of (p - o) x (q - o)
    function automatic t_pp cross_pp(input t_crd px, input t_crd py, input t_crd qx,
                                     input t_crd qy, input t_crd ox, input t_crd oy);
        t_pp t;
        t.l = mul_diff(px, ox, qy, oy);
        t.r = mul_diff(qx, ox, py, oy);
        return t;
    endfunction

    function automatic logic strict_side(input t_crs a, input t_crs b);
        return (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

    function automatic logic outside(input t_crd s0, input t_crd s1, input t_crd p);
        return (s0 > p && s1 > p) || (s0 < p && s1 < p);
    endfunction

    function automatic logic on_seg(input t_crs k, input t_crd px, input t_crd py,
                                    input t_crd s0x, input t_crd s0y,
                                    input t_crd s1x, input t_crd s1y);
        return (k == 0) && !outside(s0x, s1x, px) && !outside(s0y, s1y, py);
    endfunction

    // one restoring step for quotient bit b
    function automatic t_dv div_step(input t_dv d, input int b);
        t_dv           o;
        logic [NW-1:0] sh;
        o  = d;
        sh = NW'(d.dsor) << b;
        if (d.remx >= sh) begin
            o.remx  = d.remx - sh;
            o.qx[b] = 1'b1;
        end
        if (d.remy >= sh) begin
            o.remy  = d.remy - sh;
            o.qy[b] = 1'b1;
        end
        return o;
    endfunction

endpackage

/* hdl/segment_intersection_point_core.sv */
// Segment intersection, fully pipelined.
// Stages from accept to o_valid: products, cross terms, touch test, split
// multiply, sum, 17 restoring divider stages, output. Throughput: one item
// per cycle unless a low i_ready stalls; the 17-stage divider sets the depth.
// Reset (i_rst_n low, synchronous) clears all stage valid bits.
module segment_intersection_point_core
    import seg_ix_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_crd    i_a_start_x,
    input  t_crd    i_a_start_y,
    input  t_crd    i_a_end_x,
    input  t_crd    i_a_end_y,
    input  t_crd    i_b_start_x,
    input  t_crd    i_b_start_y,
    input  t_crd    i_b_end_x,
    input  t_crd    i_b_end_y,
    output logic    o_valid,
    input  logic    i_ready,
    output logic    o_hit,
    output logic    o_collinear_touch,
    output t_crd    o_cross_x,
    output t_crd    o_cross_y
);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: products
    logic r_v1;
    t_pp  r_pp [NK];
    t_crd r_c1 [8];
    t_pp  n_pp [NK];

    always_comb begin
        n_pp[0]  = cross_pp(i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                            i_b_start_x, i_b_start_y);
        n_pp[1]  = cross_pp(i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                            i_b_end_x, i_b_end_y);
        n_pp[2]  = cross_pp(i_b_start_x, i_b_start_y, i_a_start_x, i_a_start_y,
                            i_b_end_x, i_b_end_y);
        n_pp[3]  = cross_pp(i_b_start_x, i_b_start_y, i_a_end_x, i_a_end_y,
                            i_b_end_x, i_b_end_y);
        n_pp[4]  = cross_pp(i_a_start_x, i_a_start_y, i_b_start_x, i_b_start_y,
                            i_a_end_x, i_a_end_y);
        n_pp[5]  = cross_pp(i_a_start_x, i_a_start_y, i_b_end_x, i_b_end_y,
                            i_a_end_x, i_a_end_y);
        n_pp[6]  = cross_pp(i_a_start_x, i_a_start_y, i_b_start_x, i_b_start_y,
                            i_b_end_x, i_b_end_y);
        n_pp[7]  = cross_pp(i_a_end_x, i_a_end_y, i_b_start_x, i_b_start_y,
                            i_b_end_x, i_b_end_y);
        n_pp[8]  = cross_pp(i_b_start_x, i_b_start_y, i_a_start_x, i_a_start_y,
                            i_a_end_x, i_a_end_y);
        n_pp[9]  = cross_pp(i_b_end_x, i_b_end_y, i_a_start_x, i_a_start_y,
                            i_a_end_x, i_a_end_y);
        n_pp[KDEN].l = mul_diff(i_a_start_x, i_a_end_x, i_b_start_y, i_b_end_y);
        n_pp[KDEN].r = mul_diff(i_a_start_y, i_a_end_y, i_b_start_x, i_b_end_x);
        n_pp[KNUM].l = mul_diff(i_a_start_x, i_b_start_x, i_b_start_y, i_b_end_y);
        n_pp[KNUM].r = mul_diff(i_a_start_y, i_b_start_y, i_b_start_x, i_b_end_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_pp    <= n_pp;
            r_c1[0] <= i_a_start_x;
            r_c1[1] <= i_a_start_y;
            r_c1[2] <= i_a_end_x;
            r_c1[3] <= i_a_end_y;
            r_c1[4] <= i_b_start_x;
            r_c1[5] <= i_b_start_y;
            r_c1[6] <= i_b_end_x;
            r_c1[7] <= i_b_end_y;
        end
    end

    // stage 2: cross products
    logic r_v2;
    t_crs r_k [NK];
    t_crd r_c2 [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            for (int i = 0; i < NK; i++) begin
                r_k[i] <= XW'(r_pp[i].l) - XW'(r_pp[i].r);
            end
            r_c2 <= r_c1;
        end
    end

    // stage 3: touch decision
    logic               r_v3;
    logic               r_hit3;
    logic               r_coll3;
    t_crd               r_a0x3;
    t_crd               r_a0y3;
    logic signed [CW:0] r_dx3;
    logic signed [CW:0] r_dy3;
    t_crs               r_num3;
    t_crs               r_den3;
    logic               n_touch;

    always_comb begin
        if (r_k[0] != 0 || r_k[1] != 0) begin
            n_touch = !strict_side(r_k[2], r_k[3]) && !strict_side(r_k[4], r_k[5]);
        end else begin
            n_touch = on_seg(r_k[6], r_c2[0], r_c2[1], r_c2[4], r_c2[5], r_c2[6], r_c2[7])
                   || on_seg(r_k[7], r_c2[2], r_c2[3], r_c2[4], r_c2[5], r_c2[6], r_c2[7])
                   || on_seg(r_k[8], r_c2[4], r_c2[5], r_c2[0], r_c2[1], r_c2[2], r_c2[3])
                   || on_seg(r_k[9], r_c2[6], r_c2[7], r_c2[0], r_c2[1], r_c2[2], r_c2[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r_hit3  <= n_touch;
            r_coll3 <= n_touch && (r_k[KDEN] == 0);
            r_a0x3  <= r_c2[0];
            r_a0y3  <= r_c2[1];
            r_dx3   <= (CW+1)'(r_c2[2]) - (CW+1)'(r_c2[0]);
            r_dy3   <= (CW+1)'(r_c2[3]) - (CW+1)'(r_c2[1]);
            r_num3  <= r_k[KNUM];
            r_den3  <= r_k[KDEN];
        end
    end

    // stage 4: split magnitude multiply
    logic                r_v4;
    logic                r_hit4;
    logic                r_coll4;
    t_crd                r_a0x4;
    t_crd                r_a0y4;
    logic                r_sx4;
    logic                r_sy4;
    logic [XW-1:0]       r_dsor4;
    logic [CW+LW-1:0]    r_xlo4;
    logic [CW+HW-1:0]    r_xhi4;
    logic [CW+LW-1:0]    r_ylo4;
    logic [CW+HW-1:0]    r_yhi4;
    logic [CW-1:0]       n_dxa;
    logic [CW-1:0]       n_dya;
    logic [XW-1:0]       n_numa;

    // a coordinate difference has a magnitude of at most 2^CW - 1
    always_comb begin
        n_dxa  = r_dx3[CW] ? CW'(-r_dx3) : CW'(r_dx3);
        n_dya  = r_dy3[CW] ? CW'(-r_dy3) : CW'(r_dy3);
        n_numa = r_num3[XW-1] ? XW'(-r_num3) : XW'(r_num3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_hit4  <= r_hit3;
            r_coll4 <= r_coll3;
            r_a0x4  <= r_a0x3;
            r_a0y4  <= r_a0y3;
            r_sx4   <= r_dx3[CW] ^ r_num3[XW-1] ^ r_den3[XW-1];
            r_sy4   <= r_dy3[CW] ^ r_num3[XW-1] ^ r_den3[XW-1];
            r_dsor4 <= r_den3[XW-1] ? XW'(-r_den3) : XW'(r_den3);
            r_xlo4  <= n_dxa * n_numa[LW-1:0];
            r_xhi4  <= n_dxa * n_numa[XW-1:LW];
            r_ylo4  <= n_dya * n_numa[LW-1:0];
            r_yhi4  <= n_dya * n_numa[XW-1:LW];
        end
    end

    // stage 5 and divider stages
    logic [QB:0] r_dvv;
    t_dv         r_dv [QB+1];
    t_dv         n_dv0;

    always_comb begin
        n_dv0.hit  = r_hit4;
        n_dv0.coll = r_coll4;
        n_dv0.a0x  = r_a0x4;
        n_dv0.a0y  = r_a0y4;
        n_dv0.sx   = r_sx4;
        n_dv0.sy   = r_sy4;
        n_dv0.dsor = r_dsor4;
        n_dv0.remx = NW'(r_xlo4) + (NW'(r_xhi4) << LW);
        n_dv0.remy = NW'(r_ylo4) + (NW'(r_yhi4) << LW);
        n_dv0.qx   = '0;
        n_dv0.qy   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
        end else if (en) begin
            r_dvv <= {r_dvv[QB-1:0], r_v4};
        end
        if (en) begin
            r_dv[0] <= n_dv0;
            for (int j = 0; j < QB; j++) begin
                r_dv[j+1] <= div_step(r_dv[j], QB - 1 - j);
            end
        end
    end

    // output stage: sign, offset, clamp, miss and collinear overrides
    t_dv                r_fin;
    logic signed [CW+2:0] n_px;
    logic signed [CW+2:0] n_py;
    t_crd               n_ox;
    t_crd               n_oy;
    localparam logic signed [CW+2:0] CMAX = (CW+3)'((1 << (CW - 1)) - 1);
    localparam logic signed [CW+2:0] CMIN = -CMAX - (CW+3)'(1);

    assign r_fin = r_dv[QB];

    always_comb begin
        n_px = (CW+3)'(r_fin.a0x) +
               (r_fin.sx ? -(CW+3)'(signed'({1'b0, r_fin.qx})) :
                           (CW+3)'(signed'({1'b0, r_fin.qx})));
        n_py = (CW+3)'(r_fin.a0y) +
               (r_fin.sy ? -(CW+3)'(signed'({1'b0, r_fin.qy})) :
                           (CW+3)'(signed'({1'b0, r_fin.qy})));
        n_ox = (n_px > CMAX) ? CW'(CMAX) : (n_px < CMIN) ? CW'(CMIN) : CW'(n_px);
        n_oy = (n_py > CMAX) ? CW'(CMAX) : (n_py < CMIN) ? CW'(CMIN) : CW'(n_py);
        if (!r_fin.hit) begin
            n_ox = '0;
            n_oy = '0;
        end else if (r_fin.coll) begin
            n_ox = r_fin.a0x;
            n_oy = r_fin.a0y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dvv[QB];
        end
        if (en) begin
            o_hit             <= r_fin.hit;
            o_collinear_touch <= r_fin.coll;
            o_cross_x         <= n_ox;
            o_cross_y         <= n_oy;
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_cross_x == 0 && o_cross_y == 0 && !o_collinear_touch)
        else $error("miss with nonzero point");

    a_coll_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collinear_touch |-> o_hit)
        else $error("collinear flag without hit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_dvv) && $stable(r_v4) && $stable(r_v1))
        else $error("pipeline moved during stall");

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import seg_ix_pkg::*;

    typedef struct {
        logic       hit;
        logic       coll;
        logic [15:0] x;
        logic [15:0] y;
    } t_ixres;

    class ix_scoreboard;
        t_ixres pending[$];
        int     errors;
        int     n_hits;
        int     n_coll;
        int     n_checked;

        function longint cr3(longint px, longint py, longint qx, longint qy,
                             longint ox, longint oy);
            return (px - ox) * (qy - oy) - (qx - ox) * (py - oy);
        endfunction

        function int sg(longint v);
            return (v > 0) - (v < 0);
        endfunction

        function bit on_line_seg(longint px, longint py, longint s0x, longint s0y,
                                 longint s1x, longint s1y);
            if (cr3(px, py, s0x, s0y, s1x, s1y) != 0) return 0;
            if (sg(s0x - px) * sg(s1x - px) > 0) return 0;
            if (sg(s0y - py) * sg(s1y - py) > 0) return 0;
            return 1;
        endfunction

        function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void note_pair(t_crd c[8]);
            longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, den, num, px, py;
            bit     touch;
            t_ixres r;
            ax0 = c[0]; ay0 = c[1]; ax1 = c[2]; ay1 = c[3];
            bx0 = c[4]; by0 = c[5]; bx1 = c[6]; by1 = c[7];
            if (cr3(ax0, ay0, ax1, ay1, bx0, by0) != 0 ||
                cr3(ax0, ay0, ax1, ay1, bx1, by1) != 0) begin
                touch = !(sg(cr3(bx0, by0, ax0, ay0, bx1, by1)) *
                          sg(cr3(bx0, by0, ax1, ay1, bx1, by1)) > 0) &&
                        !(sg(cr3(ax0, ay0, bx0, by0, ax1, ay1)) *
                          sg(cr3(ax0, ay0, bx1, by1, ax1, ay1)) > 0);
            end else begin
                touch = on_line_seg(ax0, ay0, bx0, by0, bx1, by1) ||
                        on_line_seg(ax1, ay1, bx0, by0, bx1, by1) ||
                        on_line_seg(bx0, by0, ax0, ay0, ax1, ay1) ||
                        on_line_seg(bx1, by1, ax0, ay0, ax1, ay1);
            end
            r = '{hit: 0, coll: 0, x: 0, y: 0};
            if (touch) begin
                den = (ax0 - ax1) * (by0 - by1) - (ay0 - ay1) * (bx0 - bx1);
                num = (ax0 - bx0) * (by0 - by1) - (ay0 - by0) * (bx0 - bx1);
                r.hit = 1;
                if (den == 0) begin
                    r.coll = 1;
                    px = ax0;
                    py = ay0;
                end else begin
                    px = clamp16(ax0 + ((ax1 - ax0) * num) / den);
                    py = clamp16(ay0 + ((ay1 - ay0) * num) / den);
                end
                r.x = px[15:0];
                r.y = py[15:0];
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic h, logic cl, logic [15:0] x, logic [15:0] y);
            t_ixres e;
            n_checked++;
            if (pending.size() == 0) begin
                $error("result with no pending pair");
                errors++;
                return;
            end
            e = pending.pop_front();
            n_hits += e.hit;
            n_coll += e.coll;
            if (h !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, h); errors++;
            end
            if (cl !== e.coll) begin
                $error("collinear_touch exp %0d got %0d", e.coll, cl); errors++;
            end
            if (x !== e.x) begin
                $error("cross_x exp %0d got %0d", $signed(e.x), $signed(x)); errors++;
            end
            if (y !== e.y) begin
                $error("cross_y exp %0d got %0d", $signed(e.y), $signed(y)); errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    t_crd i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    t_crd i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic o_hit, o_collinear_touch;
    t_crd o_cross_x, o_cross_y;

    ix_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    int  n_pairs;

    segment_intersection_point_core u_top (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_ready = 0;
        i_a_start_x = 0; i_a_start_y = 0; i_a_end_x = 0; i_a_end_y = 0;
        i_b_start_x = 0; i_b_start_y = 0; i_b_end_x = 0; i_b_end_y = 0;
    end

    // accepted items go to the scoreboard; accepted results are checked against it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_pair('{i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                               i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y});
            if (o_valid && i_ready)
                sb.check_result(o_hit, o_collinear_touch, o_cross_x, o_cross_y);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, with calm stretches
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                i_ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk iff o_valid);
        end
    end

    task automatic send_pair(input t_crd c[8]);
        int w;
        w = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        i_valid <= 1;
        i_a_start_x <= c[0]; i_a_start_y <= c[1]; i_a_end_x <= c[2]; i_a_end_y <= c[3];
        i_b_start_x <= c[4]; i_b_start_y <= c[5]; i_b_end_x <= c[6]; i_b_end_y <= c[7];
        @(posedge i_clk iff o_ready);
        n_pairs++;
    endtask

    function automatic t_crd rnd_crd(int mode);
        case (mode)
            0: return t_crd'($urandom);
            1: return t_crd'($urandom_range(0, 64)) - 16'sd32;
            default: return t_crd'($urandom_range(0, 8000)) - 16'sd4000;
        endcase
    endfunction

    task automatic send_random();
        t_crd c[8];
        int   k, mode, dx, dy, t0, t1;
        k    = $urandom_range(0, 9);
        mode = $urandom_range(0, 2);
        foreach (c[i]) c[i] = rnd_crd(mode);
        if (k < 3) begin
            // B derived from the midpoint of A, both endpoints offset from it
            c[4] = c[0] + ((c[2] - c[0]) >>> 1) + t_crd'($urandom_range(0, 6)) - 16'sd3;
            c[5] = c[1] + ((c[3] - c[1]) >>> 1) + t_crd'($urandom_range(0, 6)) - 16'sd3;
            c[6] = c[4] - (c[6] >>> 2);
            c[7] = c[5] - (c[7] >>> 2);
            c[4] = c[4] + (c[6 - 2] >>> 3);
        end else if (k < 5) begin
            // all four points on one line
            dx = $urandom_range(0, 40) - 20;
            dy = $urandom_range(0, 40) - 20;
            c[0] = t_crd'($urandom_range(0, 2000)) - 16'sd1000;
            c[1] = t_crd'($urandom_range(0, 2000)) - 16'sd1000;
            t0 = $urandom_range(0, 20) - 10;
            t1 = $urandom_range(0, 20) - 10;
            c[2] = t_crd'(c[0] + dx * t0); c[3] = t_crd'(c[1] + dy * t0);
            t0 = $urandom_range(0, 24) - 12;
            c[4] = t_crd'(c[0] + dx * t0); c[5] = t_crd'(c[1] + dy * t0);
            c[6] = t_crd'(c[0] + dx * t1); c[7] = t_crd'(c[1] + dy * t1);
        end else if (k == 5) begin
            // shared endpoint or degenerate segment
            if ($urandom_range(0, 1)) begin
                c[4] = c[2]; c[5] = c[3];
            end else begin
                c[6] = c[4]; c[7] = c[5];
            end
        end
        send_pair(c);
    endtask

    initial begin
        t_crd mx, mn;
        mx = 16'sh7fff;
        mn = -16'sh8000;
        sb = new();
        idle_cycles = 0;
        stim_done = 0;
        n_pairs = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, crossings, collinear overlaps, degenerate cases
        send_pair('{mn, mn, mx, mx, mn, mx, mx, mn});
        send_pair('{mx, mn, mn, mx, mn, mn, mx, mx});
        send_pair('{mn, mn, mx, mn, mn, mx, mx, mx});
        send_pair('{mn, mn, mx, mx, 0, 0, mx, mx});
        send_pair('{mn, 0, mx, 0, mn, 0, mx, 0});
        send_pair('{0, 0, 16, 16, 0, 16, 16, 0});
        send_pair('{0, 0, 32, 0, 16, 0, 64, 0});
        send_pair('{0, 0, 32, 0, 48, 0, 64, 0});
        send_pair('{0, 0, 32, 0, 32, 0, 64, 0});
        send_pair('{5, 5, 5, 5, 5, 5, 5, 5});
        send_pair('{5, 5, 5, 5, 0, 0, 10, 10});
        send_pair('{5, 5, 5, 5, 0, 1, 10, 10});
        send_pair('{0, 0, 10, 10, 3, 3, 3, 3});
        send_pair('{0, 0, 10, 0, 5, 0, 5, 10});
        send_pair('{0, 0, 10, 0, 5, 1, 5, 10});
        send_pair('{0, 0, 10, 0, 0, 1, 10, 1});
        send_pair('{-1, -1, 0, 0, -1, 0, 0, -1});
        send_pair('{-16'sh5555, 16'sh2aaa, 16'sh5555, -16'sh2aaa, 0, mn, 0, mx});
        send_pair('{mx, mx, mn, mn, mn, mn, mn, mn});
        repeat (1300) send_random();
        i_valid <= 0;
        stim_done = 1;
    end

    initial begin
        @(posedge i_clk iff stim_done);
        while (sb.pending.size() != 0 && idle_cycles < 2000) @(posedge i_clk);
        if (idle_cycles >= 2000) begin
            $display("watchdog: %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            repeat (30) @(posedge i_clk);
            $display("%0d segment pairs, %0d results checked: %0d hits, %0d collinear",
                     n_pairs, sb.n_checked, sb.n_hits, sb.n_coll);
            if (sb.errors == 0 && sb.pending.size() == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stall during stimulus also trips the watchdog
    initial begin
        @(posedge i_clk iff (!stim_done && idle_cycles >= 2000));
        $display("watchdog: no progress");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
